// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and the alphabet lookup shared by the base64 decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Default number of pending group commands between front and back.
  localparam int unsigned B64D_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_LENGTH   = 2'd2,
    ERR_PADDING  = 2'd3
  } b64d_err_t;

  typedef enum logic [1:0] {
    SYM_ALPHA = 2'd0,
    SYM_PAD   = 2'd1,
    SYM_BAD   = 2'd2
  } b64d_kind_t;

  typedef struct packed {
    b64d_kind_t  kind;
    logic [5:0]  sextet;
  } b64d_sym_t;

  // Input request: one encoded character.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } b64d_char_t;

  // Output request: one decoded byte or one error.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    b64d_err_t  error_code;
  } b64d_byte_t;

  // Work for the back end: up to three bytes, or a single error result.
  typedef struct packed {
    logic [23:0] bits;   // three bytes, first byte in the top
    logic [1:0]  count;  // results to emit, 1..3
    logic        last;   // final result carries last_byte
    b64d_err_t   err;
  } b64d_cmd_t;

  function automatic b64d_sym_t b64d_classify(input logic [7:0] c);
    b64d_sym_t r;
    r.kind   = SYM_BAD;
    r.sextet = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin        // 'A'..'Z' -> 0..25
      r.kind   = SYM_ALPHA;
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin // 'a'..'z' -> 26..51
      r.kind   = SYM_ALPHA;
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin // '0'..'9' -> 52..61
      r.kind   = SYM_ALPHA;
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin               // '+'
      r.kind   = SYM_ALPHA;
      r.sextet = 6'd62;
    end else if (c == 8'h2F) begin               // '/'
      r.kind   = SYM_ALPHA;
      r.sextet = 6'd63;
    end else if (c == 8'h3D) begin               // '='
      r.kind   = SYM_PAD;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the group state and issues group commands.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  b64d_char_t char_req,
  input  logic       queue_full,
  output logic       push,
  output b64d_cmd_t  cmd
);

  logic [17:0] acc, acc_next;
  logic [1:0]  pos, pos_next;
  logic        pad_seen, pad_seen_next;
  logic        discarding, discarding_next;

  logic        accept;
  b64d_sym_t   sym;
  logic        end_flag;
  logic        do_err, do_bytes;
  b64d_err_t   err_code;
  logic [23:0] full;
  logic [1:0]  count;

  assign char_stall = queue_full;
  assign accept     = char_valid && !queue_full;
  assign sym        = b64d_classify(char_req.char_code);
  assign end_flag   = char_req.end_of_string;

  always_comb begin
    acc_next        = acc;
    pos_next        = pos;
    pad_seen_next   = pad_seen;
    discarding_next = discarding;
    do_err          = 1'b0;
    do_bytes        = 1'b0;
    err_code        = ERR_NONE;
    full            = '0;
    count           = 2'd3;
    push            = 1'b0;
    cmd             = '0;

    if (accept) begin
      if (discarding) begin
        if (end_flag) begin
          discarding_next = 1'b0;
          acc_next        = '0;
          pos_next        = '0;
          pad_seen_next   = 1'b0;
        end
      end else if (sym.kind == SYM_BAD) begin
        do_err   = 1'b1;
        err_code = ERR_BAD_CHAR;
      end else if (end_flag && pos != 2'd3) begin
        do_err   = 1'b1;
        err_code = ERR_LENGTH;
      end else if (sym.kind == SYM_PAD) begin
        if (pos < 2'd2) begin
          do_err   = 1'b1;
          err_code = ERR_PADDING;
        end else if (pos == 2'd2) begin
          // "xx=" may still become "xx==" at the end
          pad_seen_next = 1'b1;
          acc_next      = {acc[11:0], 6'd0};
          pos_next      = 2'd3;
        end else if (!end_flag) begin
          do_err   = 1'b1;
          err_code = ERR_PADDING;
        end else begin
          do_bytes = 1'b1;
          full     = {acc, 6'd0};
          count    = pad_seen ? 2'd1 : 2'd2;
        end
      end else if (pad_seen) begin
        do_err   = 1'b1;
        err_code = ERR_PADDING;
      end else if (pos < 2'd3) begin
        acc_next = {acc[11:0], sym.sextet};
        pos_next = pos + 2'd1;
      end else begin
        do_bytes = 1'b1;
        full     = {acc, sym.sextet};
        count    = 2'd3;
      end
    end

    if (do_err) begin
      push            = 1'b1;
      cmd.bits        = '0;
      cmd.count       = 2'd1;
      cmd.last        = 1'b1;
      cmd.err         = err_code;
      acc_next        = '0;
      pos_next        = '0;
      pad_seen_next   = 1'b0;
      discarding_next = !end_flag;
    end else if (do_bytes) begin
      push          = 1'b1;
      cmd.bits      = full;
      cmd.count     = count;
      cmd.last      = end_flag;
      cmd.err       = ERR_NONE;
      acc_next      = '0;
      pos_next      = '0;
      pad_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      pos        <= '0;
      pad_seen   <= 1'b0;
      discarding <= 1'b0;
    end else begin
      acc        <= acc_next;
      pos        <= pos_next;
      pad_seen   <= pad_seen_next;
      discarding <= discarding_next;
    end
  end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Small FIFO of group commands between the front and back ends.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned Depth = B64D_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  b64d_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output b64d_cmd_t head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64d_cmd_t       mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Expands group commands into byte results behind an output register.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  b64d_cmd_t  head,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_stall,
  output b64d_byte_t byte_req
);

  b64d_cmd_t  cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       adv, last_of_cur;
  logic [7:0] sel_byte;

  assign adv         = cur_valid && (!byte_valid || !byte_stall);
  assign last_of_cur = (idx == cur.count - 2'd1);
  assign pop         = head_valid && (!cur_valid || (adv && last_of_cur));

  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = cur.bits[23:16];
      2'd1:    sel_byte = cur.bits[15:8];
      default: sel_byte = cur.bits[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (adv) begin
      byte_req.data_byte  <= sel_byte;
      byte_req.last_byte  <= cur.last && last_of_cur;
      byte_req.error_code <= cur.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      idx        <= '0;
      byte_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (adv && last_of_cur) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (adv) begin
        idx <= idx + 2'd1;
      end

      if (adv) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  // An error result is a lone zero byte that closes the string.
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_req.error_code != ERR_NONE |->
      byte_req.last_byte && byte_req.data_byte == 8'd0)
    else $error("error result without last mark or with data");

  // A held command always has between one and three results.
  a_cur_count: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.count != 2'd0 && idx < cur.count)
    else $error("command index out of range");

  // A new command is loaded only once the previous one is fully emitted.
  a_pop_order: assert property (@(posedge clk) disable iff (rst)
    pop && cur_valid |-> adv && last_of_cur)
    else $error("command replaced before finishing");

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 (standard alphabet) decoder, one character per request.
// ----------------------------------------------------------------------------
// Takes one ASCII character per input request, with end_of_string on the
// final character, and returns decoded bytes one per output request. A
// character is taken every cycle as long as the command queue has room; a
// full group of four gives three bytes, so the output side keeps up at
// full input rate while byte_stall is low. The front end classifies
// characters and assembles the group; the back end plays out each group's
// bytes (up to three, one per cycle unless stalled) through a registered
// output stage. Between them sits a queue of QueueDepth group commands,
// and only that queue filling up holds the input. The last byte of a
// string carries last_byte. Errors (bad character, length not a multiple
// of four, misplaced '=') each give one zero byte with last_byte set and
// the error code, after which input is dropped through the next
// end_of_string. No configuration, no clearing pass after reset.
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int unsigned QueueDepth = B64D_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // character side
  input  logic       char_valid,
  output logic       char_stall,
  input  b64d_char_t char_req,
  // byte side
  output logic       byte_valid,
  input  logic       byte_stall,
  output b64d_byte_t byte_req
);

  logic      push, queue_full, pop, head_valid;
  b64d_cmd_t push_cmd, head;

  // Front: classify and assemble groups
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_req   (char_req),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Decouples front and back so each can stall alone
  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: one result per cycle into the output register while not stalled
  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req)
  );

endmodule
